### design/rsp_pkg.sv
// Shared types, constants and coefficient functions for the radial spotlight pixel generator.
package rsp_pkg;

    // Largest texture edge the datapath supports by default
    localparam int RSP_MAX_SIZE = 256;

    // Register reset values
    localparam logic [31:0] CENTER_RST     = 32'hFFFF00FF;
    localparam logic [31:0] BACKGROUND_RST = 32'h000000FF;
    localparam logic [8:0]  SIZE_RST       = 9'd64;
    localparam logic [11:0] POWER_RST      = 12'd768;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_CENTER     = 2'd0,
        REG_BACKGROUND = 2'd1,
        REG_SIZE       = 2'd2,
        REG_POWER      = 2'd3
    } rsp_reg_t;

    // Base special cases carried alongside the logarithm
    typedef struct packed {
        logic full;   // base is exactly 1.0
        logic zero;   // base clamped to 0
    } rsp_flag_t;

    // Integer square root of a 64-bit value, bit-pair method
    function automatic logic [31:0] rsp_isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bitv;
        res  = '0;
        rem  = v;
        bitv = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    // Q0.32 value of 2^(-2^-idx), by repeated square roots from one half
    function automatic logic [31:0] rsp_exp_coef(input int idx);
        logic [63:0] c;
        c = 64'h0000_0000_8000_0000;
        for (int i = 1; i <= 16; i++) begin
            if (i <= idx) begin
                c = {32'b0, rsp_isqrt64({c[31:0], 32'b0})};
            end
        end
        return c[31:0];
    endfunction

endpackage

### design/rsp_dist.sv
// Distance stage: centered coordinates, pipelined square root and divide, clamped base.
module rsp_dist
    import rsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [8:0]  n,
    input  logic        in_valid,
    input  logic [7:0]  row,
    input  logic [7:0]  column,
    output logic        out_valid,
    output logic [16:0] base
);

    localparam int SQ_STEPS = 26;
    localparam int DV_STEPS = 16;

    logic              in_v_reg;
    logic [7:0]        row_reg;
    logic [7:0]        col_reg;
    logic              ab_v_reg;
    logic signed [10:0] a_reg;
    logic signed [10:0] b_reg;
    logic signed [10:0] a_next;
    logic signed [10:0] b_next;
    logic signed [21:0] s_wide;
    logic [8:0]        nm1;

    logic        sq_v_reg    [0:SQ_STEPS];
    logic [25:0] sq_root_reg [0:SQ_STEPS];
    logic [27:0] sq_rem_reg  [0:SQ_STEPS-1];
    logic [19:0] sq_s_reg    [0:SQ_STEPS-1];
    logic [25:0] sq_root_next [0:SQ_STEPS-1];
    logic [27:0] sq_rem_next  [0:SQ_STEPS-1];
    logic [19:0] sq_s_next    [0:SQ_STEPS-1];

    logic        dv_v_reg    [0:DV_STEPS];
    logic        dv_over_reg [0:DV_STEPS];
    logic [15:0] dv_q_reg    [0:DV_STEPS];
    logic [25:0] dv_rem_reg  [0:DV_STEPS-1];
    logic [15:0] dv_q_next   [0:DV_STEPS-1];
    logic [25:0] dv_rem_next [0:DV_STEPS-1];

    logic        base_v_reg;
    logic [16:0] base_reg;

    // Center and scale the coordinates by two so they stay integer
    assign nm1    = n - 9'd1;
    assign a_next = $signed({2'b00, col_reg, 1'b0}) - $signed({2'b00, nm1});
    assign b_next = $signed({2'b00, row_reg, 1'b0}) - $signed({2'b00, nm1});
    assign s_wide = a_reg * a_reg + b_reg * b_reg;

    // Hold the request, then the centered coordinates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
            ab_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg <= in_valid;
            ab_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row_reg <= row;
            col_reg <= column;
            a_reg   <= a_next;
            b_reg   <= b_next;
        end
    end

    // One root bit per stage; the low 32 bits of the radicand are zero
    always_comb begin
        for (int j = 0; j < SQ_STEPS; j++) begin
            logic [29:0] rem_sh;
            logic [29:0] trial;
            logic        ge;
            rem_sh = {sq_rem_reg[j], sq_s_reg[j][19:18]};
            trial  = {2'b00, sq_root_reg[j], 2'b01};
            ge     = rem_sh >= trial;
            sq_rem_next[j]  = ge ? 28'(rem_sh - trial) : rem_sh[27:0];
            sq_root_next[j] = {sq_root_reg[j][24:0], ge};
            sq_s_next[j]    = {sq_s_reg[j][17:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= SQ_STEPS; j++) sq_v_reg[j] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= ab_v_reg;
            for (int j = 0; j < SQ_STEPS; j++) sq_v_reg[j+1] <= sq_v_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_s_reg[0]    <= s_wide[19:0];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int j = 0; j < SQ_STEPS; j++) sq_root_reg[j+1] <= sq_root_next[j];
            for (int j = 0; j < SQ_STEPS - 1; j++) begin
                sq_rem_reg[j+1] <= sq_rem_next[j];
                sq_s_reg[j+1]   <= sq_s_next[j];
            end
        end
    end

    // Restoring divide by the edge length, one quotient bit per stage
    always_comb begin
        for (int j = 0; j < DV_STEPS; j++) begin
            logic [25:0] dsh;
            logic        ge;
            dsh = 26'(n) << (DV_STEPS - 1 - j);
            ge  = dv_rem_reg[j] >= dsh;
            dv_rem_next[j] = ge ? dv_rem_reg[j] - dsh : dv_rem_reg[j];
            dv_q_next[j]   = {dv_q_reg[j][14:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= DV_STEPS; j++) dv_v_reg[j] <= 1'b0;
            base_v_reg <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= sq_v_reg[SQ_STEPS];
            for (int j = 0; j < DV_STEPS; j++) dv_v_reg[j+1] <= dv_v_reg[j];
            base_v_reg <= dv_v_reg[DV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Quotient of 2^16 or more means the pixel is on or past the rim
            dv_over_reg[0] <= sq_root_reg[SQ_STEPS] >= {1'b0, n, 16'b0};
            dv_rem_reg[0]  <= sq_root_reg[SQ_STEPS];
            dv_q_reg[0]    <= '0;
            for (int j = 0; j < DV_STEPS; j++) begin
                dv_over_reg[j+1] <= dv_over_reg[j];
                dv_q_reg[j+1]    <= dv_q_next[j];
            end
            for (int j = 0; j < DV_STEPS - 1; j++) dv_rem_reg[j+1] <= dv_rem_next[j];
            base_reg <= dv_over_reg[DV_STEPS] ? 17'd0
                                              : 17'h10000 - {1'b0, dv_q_reg[DV_STEPS]};
        end
    end

    assign out_valid = base_v_reg;
    assign base      = base_reg;

endmodule

### design/rsp_log.sv
// Log stage: normalize the base and extract -log2 by sixteen squaring steps.
module rsp_log
    import rsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [16:0] base,
    output logic        out_valid,
    output logic [20:0] lg,
    output rsp_flag_t   flag
);

    localparam int SQ_STEPS = 16;

    logic        v_reg   [0:SQ_STEPS];
    logic [3:0]  k_reg   [0:SQ_STEPS];
    rsp_flag_t   fl_reg  [0:SQ_STEPS];
    logic [15:0] x_reg   [0:SQ_STEPS-1];
    logic [15:0] f_reg   [0:SQ_STEPS];
    logic [15:0] x_next  [0:SQ_STEPS-1];
    logic [15:0] f_next  [0:SQ_STEPS-1];

    logic [3:0]  k_lead;
    logic [15:0] m_norm;
    rsp_flag_t   fl_in;

    logic        lg_v_reg;
    logic [20:0] lg_reg;
    rsp_flag_t   lg_fl_reg;

    // Find the leading one and normalize the mantissa to Q1.15
    always_comb begin
        k_lead = '0;
        for (int i = 0; i < 16; i++) begin
            if (base[i]) k_lead = 4'(i);
        end
        m_norm     = base[15:0] << (4'd15 - k_lead);
        fl_in.full = base[16];
        fl_in.zero = (base == 17'd0);
    end

    // Square and renormalize, one fraction bit per stage
    always_comb begin
        for (int j = 0; j < SQ_STEPS; j++) begin
            logic [31:0] sq;
            logic [16:0] y;
            sq = x_reg[j] * x_reg[j];
            y  = sq[31:15];
            x_next[j] = y[16] ? y[16:1] : y[15:0];
            f_next[j] = {f_reg[j][14:0], y[16]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= SQ_STEPS; j++) v_reg[j] <= 1'b0;
            lg_v_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int j = 0; j < SQ_STEPS; j++) v_reg[j+1] <= v_reg[j];
            lg_v_reg <= v_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg[0]  <= k_lead;
            fl_reg[0] <= fl_in;
            x_reg[0]  <= m_norm;
            f_reg[0]  <= '0;
            for (int j = 0; j < SQ_STEPS; j++) begin
                k_reg[j+1]  <= k_reg[j];
                fl_reg[j+1] <= fl_reg[j];
                f_reg[j+1]  <= f_next[j];
            end
            for (int j = 0; j < SQ_STEPS - 1; j++) x_reg[j+1] <= x_next[j];
            // Integer part from the leading-one position, fraction from the squarings
            lg_reg    <= {5'd16 - {1'b0, k_reg[SQ_STEPS]}, 16'b0}
                         - {5'b0, f_reg[SQ_STEPS]};
            lg_fl_reg <= fl_reg[SQ_STEPS];
        end
    end

    assign out_valid = lg_v_reg;
    assign lg        = lg_reg;
    assign flag      = lg_fl_reg;

endmodule

### design/rsp_pow.sv
// Power stage: scale the log by the exponent and rebuild the weight from root-of-two factors.
module rsp_pow
    import rsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [11:0] power,
    input  logic        in_valid,
    input  logic [20:0] lg,
    input  rsp_flag_t   flag,
    output logic        out_valid,
    output logic [16:0] weight
);

    localparam int PD_STEPS = 16;

    logic [31:0] coef [0:PD_STEPS-1];

    for (genvar i = 0; i < PD_STEPS; i++) begin : g_coef
        localparam logic [31:0] COEF_VAL = rsp_exp_coef(i + 1);
        assign coef[i] = COEF_VAL;
    end

    logic        e_v_reg;
    logic [24:0] e_reg;
    logic        ov_reg;
    logic        ov_one_reg;
    logic [32:0] e_prod;

    logic        pd_v_reg      [0:PD_STEPS];
    logic [31:0] pd_acc_reg    [0:PD_STEPS];
    logic        pd_one_reg    [0:PD_STEPS];
    logic [15:0] pd_g_reg      [0:PD_STEPS-1];
    logic [4:0]  pd_q_reg      [0:PD_STEPS];
    logic        pd_big_reg    [0:PD_STEPS];
    logic        pd_ov_reg     [0:PD_STEPS];
    logic        pd_ov_one_reg [0:PD_STEPS];
    logic [31:0] pd_acc_next   [0:PD_STEPS-1];
    logic        pd_one_next   [0:PD_STEPS-1];

    logic        w_v_reg;
    logic [16:0] w_reg;
    logic [16:0] w_next;
    logic [16:0] w_mant;

    // Exponent times log, Q.16 result
    assign e_prod = lg * power;

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg      <= e_prod[32:8];
            ov_reg     <= flag.full | flag.zero;
            ov_one_reg <= flag.full | (power == 12'd0);
        end
    end

    // Multiply in one factor per set fraction bit, starting from exactly one
    always_comb begin
        for (int j = 0; j < PD_STEPS; j++) begin
            logic [63:0] prod;
            prod = pd_acc_reg[j] * coef[j];
            pd_acc_next[j] = pd_acc_reg[j];
            pd_one_next[j] = pd_one_reg[j];
            if (pd_g_reg[j][15]) begin
                pd_acc_next[j] = pd_one_reg[j] ? coef[j] : prod[63:32];
                pd_one_next[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_v_reg <= 1'b0;
            for (int j = 0; j <= PD_STEPS; j++) pd_v_reg[j] <= 1'b0;
            w_v_reg <= 1'b0;
        end else if (en) begin
            e_v_reg     <= in_valid;
            pd_v_reg[0] <= e_v_reg;
            for (int j = 0; j < PD_STEPS; j++) pd_v_reg[j+1] <= pd_v_reg[j];
            w_v_reg     <= pd_v_reg[PD_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pd_acc_reg[0]    <= '0;
            pd_one_reg[0]    <= 1'b1;
            pd_g_reg[0]      <= e_reg[15:0];
            pd_q_reg[0]      <= e_reg[20:16];
            pd_big_reg[0]    <= e_reg[24:16] > 9'd16;
            pd_ov_reg[0]     <= ov_reg;
            pd_ov_one_reg[0] <= ov_one_reg;
            for (int j = 0; j < PD_STEPS; j++) begin
                pd_acc_reg[j+1]    <= pd_acc_next[j];
                pd_one_reg[j+1]    <= pd_one_next[j];
                pd_q_reg[j+1]      <= pd_q_reg[j];
                pd_big_reg[j+1]    <= pd_big_reg[j];
                pd_ov_reg[j+1]     <= pd_ov_reg[j];
                pd_ov_one_reg[j+1] <= pd_ov_one_reg[j];
            end
            for (int j = 0; j < PD_STEPS - 1; j++) pd_g_reg[j+1] <= {pd_g_reg[j][14:0], 1'b0};
            w_reg <= w_next;
        end
    end

    // Apply the integer part as a right shift (zero above 16); the base special cases override it
    always_comb begin
        w_mant = pd_one_reg[PD_STEPS] ? 17'h10000 : {1'b0, pd_acc_reg[PD_STEPS][31:16]};
        if (pd_ov_reg[PD_STEPS]) begin
            w_next = pd_ov_one_reg[PD_STEPS] ? 17'h10000 : 17'd0;
        end else if (pd_big_reg[PD_STEPS]) begin
            w_next = 17'd0;
        end else begin
            w_next = w_mant >> pd_q_reg[PD_STEPS];
        end
    end

    assign out_valid = w_v_reg;
    assign weight    = w_reg;

endmodule

### design/rsp_blend.sv
// Blend stage: mix center and background bytes by the weight.
module rsp_blend
    import rsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [31:0] center,
    input  logic [31:0] background,
    input  logic        in_valid,
    input  logic [16:0] weight,
    output logic        out_valid,
    output logic [7:0]  chan [0:3]
);

    logic        pr_v_reg;
    logic [24:0] cp_reg [0:3];
    logic [24:0] bp_reg [0:3];
    logic        ch_v_reg;
    logic [7:0]  ch_reg [0:3];
    logic [16:0] w_inv;

    assign w_inv = 17'h10000 - weight;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_v_reg <= 1'b0;
            ch_v_reg <= 1'b0;
        end else if (en) begin
            pr_v_reg <= in_valid;
            ch_v_reg <= pr_v_reg;
        end
    end

    // Products per channel, red in the top byte, then sum and truncate
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                logic [25:0] sum;
                cp_reg[c] <= center[31 - 8*c -: 8] * weight;
                bp_reg[c] <= background[31 - 8*c -: 8] * w_inv;
                sum = {1'b0, cp_reg[c]} + {1'b0, bp_reg[c]};
                ch_reg[c] <= sum[23:16];
            end
        end
    end

    assign out_valid = ch_v_reg;
    assign chan      = ch_reg;

endmodule

### design/radial_spotlight_pixel_generator.sv
// Top level of the radial spotlight pixel generator: registers, pipeline and output skid.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_row, s_column
//   m_        out        m_valid/m_ready    m_red, m_green, m_blue, m_alpha
//   APB       in/out     psel/penable       paddr, pwdata, prdata (pready tied high)
//
// One pixel enters per clock while s_ready is high, that is while the skid is empty.
// The depth is set by the square root (one bit per stage), the divide by the edge
// length, sixteen squaring stages for the log and sixteen multiply stages for the power.
// Reset is synchronous, active low; it empties the pipeline and loads register defaults.
// When the output stalls, a one-entry skid catches the pixel in flight, then s_ready drops.
module radial_spotlight_pixel_generator
    import rsp_pkg::*;
#(
    parameter int MAX_SIZE = RSP_MAX_SIZE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_row,
    input  logic [7:0]  s_column,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha
);

    logic [31:0] center_reg;
    logic [31:0] background_reg;
    logic [8:0]  size_reg;
    logic [11:0] power_reg;
    logic [8:0]  n_eff;
    logic        wr_en;
    rsp_reg_t    reg_sel;

    logic        en;
    logic        dist_v;
    logic [16:0] dist_base;
    logic        log_v;
    logic [20:0] log_lg;
    rsp_flag_t   log_flag;
    logic        pow_v;
    logic [16:0] pow_w;
    logic        bl_v;
    logic [7:0]  bl_chan [0:3];

    logic        m_valid_reg;
    logic [7:0]  m_chan_reg [0:3];
    logic        skid_valid_reg;
    logic [7:0]  skid_chan_reg [0:3];

    // Register file
    assign pready  = 1'b1;
    assign reg_sel = rsp_reg_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg     <= CENTER_RST;
            background_reg <= BACKGROUND_RST;
            size_reg       <= SIZE_RST;
            power_reg      <= POWER_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_CENTER:     center_reg     <= pwdata;
                REG_BACKGROUND: background_reg <= pwdata;
                REG_SIZE:       size_reg       <= pwdata[8:0];
                REG_POWER:      power_reg      <= pwdata[11:0];
                default:        center_reg     <= center_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_CENTER:     prdata = center_reg;
            REG_BACKGROUND: prdata = background_reg;
            REG_SIZE:       prdata = {23'b0, size_reg};
            REG_POWER:      prdata = {20'b0, power_reg};
            default:        prdata = '0;
        endcase
    end

    // Clamp the edge length to 1..MAX_SIZE
    always_comb begin
        if (size_reg == 9'd0) begin
            n_eff = 9'd1;
        end else if (32'(size_reg) > MAX_SIZE) begin
            n_eff = 9'(MAX_SIZE);
        end else begin
            n_eff = size_reg;
        end
    end

    // Advance the whole pipeline unless the skid holds a pixel
    assign en      = ~skid_valid_reg;
    assign s_ready = en;

    rsp_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .n         (n_eff),
        .in_valid  (s_valid),
        .row       (s_row),
        .column    (s_column),
        .out_valid (dist_v),
        .base      (dist_base)
    );

    rsp_log u_log (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dist_v),
        .base      (dist_base),
        .out_valid (log_v),
        .lg        (log_lg),
        .flag      (log_flag)
    );

    rsp_pow u_pow (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .power     (power_reg),
        .in_valid  (log_v),
        .lg        (log_lg),
        .flag      (log_flag),
        .out_valid (pow_v),
        .weight    (pow_w)
    );

    rsp_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .center     (center_reg),
        .background (background_reg),
        .in_valid   (pow_v),
        .weight     (pow_w),
        .out_valid  (bl_v),
        .chan       (bl_chan)
    );

    // Output register with a one-entry skid behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= en & bl_v;
            end
        end else if (en && bl_v) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_chan_reg <= skid_chan_reg;
            end else if (en && bl_v) begin
                m_chan_reg <= bl_chan;
            end
        end else if (en && bl_v) begin
            skid_chan_reg <= bl_chan;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = m_chan_reg[0];
    assign m_green = m_chan_reg[1];
    assign m_blue  = m_chan_reg[2];
    assign m_alpha = m_chan_reg[3];

endmodule

### design/rsp_checker.sv
// Port-level checks for the radial spotlight pixel generator, bound to the top level.
module rsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_row,
    input logic [7:0]  s_column,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_red,
    input logic [7:0]  m_green,
    input logic [7:0]  m_blue,
    input logic [7:0]  m_alpha
);

    // Hold a stalled result
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
                                && $stable(m_blue) && $stable(m_alpha))
        else $error("stalled result changed or dropped");

    // Drop the output after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Refuse requests only while a result waits at the output
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !$past(m_ready))
        else $error("input stalled without a waiting result");

    // Read back an edge-length write
    a_size_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && paddr[3:2] == 2'd2
        |=> paddr[3:2] != 2'd2 || prdata == {23'b0, $past(pwdata[8:0])})
        else $error("edge length register readback mismatch");

endmodule

bind radial_spotlight_pixel_generator rsp_checker u_rsp_checker (.*);

### dv/tb_radial_spotlight_pixel_generator.sv
// Self-checking testbench for the radial spotlight pixel generator: directed table, random pixels.
`timescale 1ns / 1ps

module tb_radial_spotlight_pixel_generator
    import rsp_pkg::*;
();

    localparam int LATENCY = 87;
    localparam int MAXN    = 256;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct {
        logic [7:0] row;
        logic [7:0] column;
        logic       known;
        pixel_t     px;
    } vector_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_row;
    logic [7:0]  s_column;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [7:0]  m_alpha;

    // Shadow copy of the registers
    logic [31:0] sh_center;
    logic [31:0] sh_background;
    logic [8:0]  sh_size;
    logic [11:0] sh_power;

    pixel_t  pending_pixels[$];
    vector_t directed_rows[$];
    int      errors;
    bit      idle_free;
    bit      long_hold;
    logic [63:0] exp_coef[17];

    radial_spotlight_pixel_generator u_top (.*);

    // Generate clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Bit-pair integer square root
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Weight = base ^ power, through log2 and a product of root coefficients
    function automatic logic [16:0] falloff_weight(input logic [16:0] base, input logic [11:0] p);
        int          k;
        logic [63:0] x;
        logic [15:0] f;
        logic [63:0] e;
        logic [63:0] acc;
        logic [31:0] q;
        logic [15:0] g;
        if (base >= 17'd65536) return 17'd65536;
        if (base == 0) return (p == 0) ? 17'd65536 : 17'd0;
        k = 15;
        while (base[k] == 1'b0) k--;
        x = 64'(base) << (15 - k);
        f = '0;
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 15;
            f = f << 1;
            if (x >= 64'd65536) begin
                f[0] = 1'b1;
                x = x >> 1;
            end
        end
        e = (((64'(16 - k)) << 16) - 64'(f)) * 64'(p) >> 8;
        q = e[47:16];
        g = e[15:0];
        if (q > 16) return 17'd0;
        acc = 64'd1 << 32;
        for (int i = 1; i <= 16; i++)
            if (g[16-i]) acc = (acc * exp_coef[i]) >> 32;
        return 17'((acc >> 16) >> q);
    endfunction

    // Expected RGBA for one pixel under the shadow registers
    function automatic pixel_t spot_pixel(input logic [7:0] row, input logic [7:0] column);
        longint      n;
        longint      a;
        longint      b;
        logic [63:0] s;
        logic [63:0] dq;
        logic [16:0] base;
        logic [16:0] w;
        logic [31:0] chans;
        logic [63:0] cb;
        logic [63:0] bb;
        n = sh_size;
        if (n < 1) n = 1;
        if (n > MAXN) n = MAXN;
        a = 2 * longint'(column) - (n - 1);
        b = 2 * longint'(row) - (n - 1);
        s = 64'(a * a) + 64'(b * b);
        dq = int_sqrt(s << 32) / 64'(n);
        base = (dq < 64'd65536) ? 17'(64'd65536 - dq) : 17'd0;
        w = falloff_weight(base, sh_power);
        for (int ch = 0; ch < 4; ch++) begin
            cb = 64'((sh_center >> (24 - 8 * ch)) & 32'hFF);
            bb = 64'((sh_background >> (24 - 8 * ch)) & 32'hFF);
            chans[31 - 8 * ch -: 8] = 8'((cb * w + bb * (64'd65536 - w)) >> 16);
        end
        return pixel_t'(chans);
    endfunction

    // Write one register through the APB port, shadow it too
    task automatic write_reg(input rsp_reg_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_CENTER:     sh_center     = value;
            REG_BACKGROUND: sh_background = value;
            REG_SIZE:       sh_size       = value[8:0];
            REG_POWER:      sh_power      = value[11:0];
            default: ;
        endcase
    endtask

    // Offer one request and hold it until taken
    task automatic send_pixel(input logic [7:0] row, input logic [7:0] column,
                              input bit known, input pixel_t px);
        int gap;
        if (!idle_free && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_row    <= row;
        s_column <= column;
        pending_pixels.push_back(known ? px : spot_pixel(row, column));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drain the pipeline before touching registers
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    // Receiver: random stalls, one long hold-off
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 1'b0;
            end else if (!idle_free && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 17);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel %h %h %h %h", $time,
                         m_red, m_green, m_blue, m_alpha);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_red !== want.red) begin
                    $display("%0t: red expected %h actual %h", $time, want.red, m_red);
                    errors++;
                end
                if (m_green !== want.green) begin
                    $display("%0t: green expected %h actual %h", $time, want.green, m_green);
                    errors++;
                end
                if (m_blue !== want.blue) begin
                    $display("%0t: blue expected %h actual %h", $time, want.blue, m_blue);
                    errors++;
                end
                if (m_alpha !== want.alpha) begin
                    $display("%0t: alpha expected %h actual %h", $time, want.alpha, m_alpha);
                    errors++;
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    // Main stimulus
    initial begin
        vector_t     v;
        logic [7:0]  r;
        logic [7:0]  c;
        int          sz;
        errors    = 0;
        idle_free = 1'b0;
        long_hold = 1'b0;
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_row     = '0;
        s_column  = '0;
        sh_center     = CENTER_RST;
        sh_background = BACKGROUND_RST;
        sh_size       = SIZE_RST;
        sh_power      = POWER_RST;
        exp_coef[0] = 64'd1 << 31;
        for (int i = 1; i <= 16; i++) exp_coef[i] = int_sqrt(exp_coef[i-1] << 32);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table under reset registers; far corners and outside pixels are background
        directed_rows.push_back('{8'd0,   8'd0,   1'b1, pixel_t'(32'h000000FF)});
        directed_rows.push_back('{8'd63,  8'd0,   1'b1, pixel_t'(32'h000000FF)});
        directed_rows.push_back('{8'd255, 8'd255, 1'b1, pixel_t'(32'h000000FF)});
        directed_rows.push_back('{8'd64,  8'd10,  1'b1, pixel_t'(32'h000000FF)});
        directed_rows.push_back('{8'd31,  8'd31,  1'b0, '0});
        directed_rows.push_back('{8'd32,  8'd32,  1'b0, '0});
        directed_rows.push_back('{8'd31,  8'd40,  1'b0, '0});
        directed_rows.push_back('{8'd10,  8'd31,  1'b0, '0});
        foreach (directed_rows[i]) begin
            v = directed_rows[i];
            send_pixel(v.row, v.column, v.known, v.px);
        end
        drain();

        // Odd size: the centre pixel has base 1.0, weight one gives the centre color
        write_reg(REG_SIZE, 32'd63);
        send_pixel(8'd31, 8'd31, 1'b1, pixel_t'(32'hFFFF00FF));
        send_pixel(8'd0, 8'd62, 1'b0, '0);
        drain();
        // Power zero: even outside pixels take the centre color
        write_reg(REG_POWER, 32'd0);
        write_reg(REG_CENTER, 32'h12345678);
        write_reg(REG_BACKGROUND, 32'hFFFFFFFF);
        send_pixel(8'd255, 8'd0, 1'b1, pixel_t'(32'h12345678));
        send_pixel(8'd20, 8'd5, 1'b1, pixel_t'(32'h12345678));
        drain();
        // Size zero and above the limit, maximum power
        write_reg(REG_SIZE, 32'd0);
        write_reg(REG_POWER, 32'hFFF);
        send_pixel(8'd0, 8'd0, 1'b1, pixel_t'(32'h12345678));
        send_pixel(8'd1, 8'd0, 1'b0, '0);
        drain();
        write_reg(REG_SIZE, 32'h1FF);
        send_pixel(8'd128, 8'd128, 1'b0, '0);
        send_pixel(8'd255, 8'd127, 1'b0, '0);
        drain();
        write_reg(REG_SIZE, 32'd256);
        write_reg(REG_POWER, 32'd1);
        send_pixel(8'd127, 8'd128, 1'b0, '0);
        send_pixel(8'd200, 8'd90, 1'b0, '0);
        drain();

        // Random phases with fresh settings
        for (int ph = 0; ph < 9; ph++) begin
            write_reg(REG_CENTER, $urandom());
            write_reg(REG_BACKGROUND, $urandom());
            case (ph % 3)
                0: sz = $urandom_range(1, 32);
                1: sz = $urandom_range(0, 511);
                default: sz = 256;
            endcase
            write_reg(REG_SIZE, 32'(sz));
            write_reg(REG_POWER, (ph == 4) ? 32'hFFF : 32'($urandom_range(0, 4095)));
            if (ph == 3) long_hold = 1'b1;
            if (ph == 8) idle_free = 1'b1;
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = 8'($urandom());
                    c = 8'($urandom());
                end else begin
                    r = 8'($urandom_range(0, (sz < 1 ? 1 : (sz > 256 ? 256 : sz)) - 1));
                    c = 8'($urandom_range(0, (sz < 1 ? 1 : (sz > 256 ? 256 : sz)) - 1));
                end
                send_pixel(r, c, 1'b0, '0);
            end
            drain();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
